// ===== rtl/pit_pkg.sv =====
package pit_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register map
    localparam logic [3:0] ADDR_ENABLE      = 4'd0;
    localparam logic [3:0] ADDR_FORCE_LOAD  = 4'd1;
    localparam logic [3:0] ADDR_CH_ENABLE   = 4'd2;
    localparam logic [3:0] ADDR_SELECT      = 4'd3;
    localparam logic [3:0] ADDR_IRQ_ENABLE  = 4'd4;
    localparam logic [3:0] ADDR_FLAGS       = 4'd5;
    localparam logic [3:0] ADDR_MICRO_LOAD0 = 4'd6;
    localparam logic [3:0] ADDR_MICRO_LOAD1 = 4'd7;
    localparam logic [3:0] ADDR_CH_LOAD     = 4'd8;
    localparam logic [3:0] ADDR_CH_COUNT    = 4'd12;

    // channels reachable through the load and counter windows
    localparam int MAP_CHANNELS = 4;

    // force-load bit of micro-timer 0, micro-timer 1 is the next bit up
    localparam int FORCE_MICRO_LSB = 8;

    localparam int MICRO_BITS = 8;
    localparam int NUM_MICRO  = 2;

    // per-counter control from the register decode
    typedef struct packed {
        logic count_en;
        logic reload;
        logic load_we;
    } pit_ctrl_t;

endpackage

// ===== rtl/pit_micro.sv =====
module pit_micro
    import pit_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pit_ctrl_t             ctrl,
    input  logic [MICRO_BITS-1:0] load_wdata,
    output logic                  pulse,
    output logic [MICRO_BITS-1:0] load_q
);

    logic [MICRO_BITS-1:0] load_reg,  load_next;
    logic [MICRO_BITS-1:0] count_reg, count_next;

    assign pulse  = ctrl.count_en && (count_reg == '0);
    assign load_q = load_reg;

    always_comb begin
        load_next  = load_reg;
        count_next = count_reg;
        if (ctrl.load_we) begin
            load_next = load_wdata;
        end
        priority if (ctrl.reload || pulse) begin
            count_next = load_reg;
        end else if (ctrl.count_en) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg  <= '0;
            count_reg <= '0;
        end else begin
            load_reg  <= load_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/pit_channel.sv =====
module pit_chan_counter
    import pit_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pit_ctrl_t             ctrl,
    input  logic [COUNT_BITS-1:0] load_wdata,
    output logic                  wrap,
    output logic [COUNT_BITS-1:0] load_q,
    output logic [COUNT_BITS-1:0] count_q
);

    logic [COUNT_BITS-1:0] load_reg,  load_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign wrap    = ctrl.count_en && (count_reg == '0);
    assign load_q  = load_reg;
    assign count_q = count_reg;

    always_comb begin
        load_next  = load_reg;
        count_next = count_reg;
        if (ctrl.load_we) begin
            load_next = load_wdata;
        end
        priority if (ctrl.reload || wrap) begin
            count_next = load_reg;
        end else if (ctrl.count_en) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg  <= '0;
            count_reg <= '0;
        end else begin
            load_reg  <= load_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/periodic_interrupt_timer_unit.sv =====
// periodic interrupt timer, several channels fed by two 8-bit micro-timers
//
// input stream: one transfer per operation; tuser holds the command (bus tick,
// register write, register read), tdata the register address and write data.
// result stream: exactly one transfer per input transfer, holding the read data
// (zero unless a read), the timeout flags after the operation and the irq level.
//
// path: an accepted transfer waits in the input register, then the whole state
// update and read mux run in a single pass into the result register, which
// drives m_tvalid.
// throughput: one transfer per cycle while the receiver does not stall; the
// micro-timer and channel counters update at most once per operation.
//
// if the receiver stalls, the result register holds and the input register still
// takes one more transfer; state only moves when an operation reaches the result
// register, so a stall freezes all counters.
//
// reset (aresetn low, synchronous) clears the valid and state registers: block disabled, all
// channels off and on micro-timer 0, loads, counters and flags zero; payload registers are not reset.
module periodic_interrupt_timer_unit
    import pit_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_addr[3:0], write_data[19:4], zero[23:20]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_data[15:0], flag_bits[19:16], irq[20], zero[23:21]
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  cmd_reg;
    logic [3:0]  addr_reg;
    logic [15:0] data_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] rd_reg,  rd_next;
    logic [3:0]  fout_reg, fout_next;
    logic        irq_reg, irq_next;

    // global control state
    logic                    ge_reg,     ge_next;
    logic [NUM_CHANNELS-1:0] ch_en_reg,  ch_en_next;
    logic [NUM_CHANNELS-1:0] sel_reg,    sel_next;
    logic [NUM_CHANNELS-1:0] irq_en_reg, irq_en_next;
    logic [NUM_CHANNELS-1:0] flags_reg,  flags_next;

    logic fire;      // operation moves from input to result register
    logic is_tick;   // tick that actually advances the timers
    logic is_wr;
    logic ge_rise;

    logic [NUM_MICRO-1:0]    pulse;
    logic [MICRO_BITS-1:0]   micro_load_q [NUM_MICRO];
    logic [NUM_CHANNELS-1:0] wrap;
    logic [COUNT_BITS-1:0]   ch_load_q  [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   ch_count_q [NUM_CHANNELS];
    logic [31:0]             wdata_ext;
    logic [COUNT_BITS-1:0]   ch_wdata;

    pit_ctrl_t micro_ctrl [NUM_MICRO];
    pit_ctrl_t ch_ctrl    [NUM_CHANNELS];

    // handshake: the input register refills whenever its item moves on
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, irq_reg, fout_reg, rd_reg};

    assign is_tick = fire && (cmd_reg == CMD_TICK) && ge_reg;
    assign is_wr   = fire && (cmd_reg == CMD_WRITE);
    assign ge_rise = is_wr && (addr_reg == ADDR_ENABLE) && data_reg[0] && !ge_reg;

    // write data sized to the channel count width
    assign wdata_ext = {16'h0000, data_reg};
    assign ch_wdata  = wdata_ext[COUNT_BITS-1:0];

    // micro-timers: time base for the channels
    for (genvar m = 0; m < NUM_MICRO; m++) begin : g_micro
        assign micro_ctrl[m].count_en = is_tick;
        assign micro_ctrl[m].reload   = ge_rise
            || (is_wr && (addr_reg == ADDR_FORCE_LOAD) && data_reg[FORCE_MICRO_LSB + m]);
        assign micro_ctrl[m].load_we  = is_wr
            && (addr_reg == 4'(32'(ADDR_MICRO_LOAD0) + m));

        pit_micro u_micro (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (micro_ctrl[m]),
            .load_wdata (data_reg[MICRO_BITS-1:0]),
            .pulse      (pulse[m]),
            .load_q     (micro_load_q[m])
        );
    end

    // channels: count pulses of the selected micro-timer
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        localparam bit MAPPED = (c < MAP_CHANNELS);

        assign ch_ctrl[c].count_en = is_tick && ch_en_reg[c] && pulse[sel_reg[c]];
        // reload on global enable rising, force load, or channel enable rising
        assign ch_ctrl[c].reload   = (ge_rise && ch_en_reg[c])
            || (is_wr && (addr_reg == ADDR_FORCE_LOAD) && data_reg[c])
            || (is_wr && (addr_reg == ADDR_CH_ENABLE) && data_reg[c] && !ch_en_reg[c]);
        assign ch_ctrl[c].load_we  = MAPPED && is_wr
            && (addr_reg == 4'(32'(ADDR_CH_LOAD) + c));

        pit_chan_counter #(
            .COUNT_BITS (COUNT_BITS)
        ) u_channel (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ch_ctrl[c]),
            .load_wdata (ch_wdata),
            .wrap       (wrap[c]),
            .load_q     (ch_load_q[c]),
            .count_q    (ch_count_q[c])
        );
    end

    // global registers and flags
    always_comb begin
        ge_next     = ge_reg;
        ch_en_next  = ch_en_reg;
        sel_next    = sel_reg;
        irq_en_next = irq_en_reg;
        flags_next  = flags_reg | wrap;
        if (is_wr) begin
            unique case (addr_reg)
                ADDR_ENABLE:     ge_next     = data_reg[0];
                ADDR_CH_ENABLE:  ch_en_next  = data_reg[NUM_CHANNELS-1:0];
                ADDR_SELECT:     sel_next    = data_reg[NUM_CHANNELS-1:0];
                ADDR_IRQ_ENABLE: irq_en_next = data_reg[NUM_CHANNELS-1:0];
                ADDR_FLAGS:      flags_next  = flags_reg & ~data_reg[NUM_CHANNELS-1:0];
                default:         ;
            endcase
        end
    end

    // read mux and result
    always_comb begin
        logic [31:0] wide;
        logic [7:0]  flags8;
        wide   = '0;
        flags8 = 8'(flags_next);
        rd_next = '0;
        if (cmd_reg == CMD_READ) begin
            unique case (addr_reg)
                ADDR_ENABLE:      rd_next = {15'h0000, ge_reg};
                ADDR_CH_ENABLE:   rd_next = 16'(ch_en_reg);
                ADDR_SELECT:      rd_next = 16'(sel_reg);
                ADDR_IRQ_ENABLE:  rd_next = 16'(irq_en_reg);
                ADDR_FLAGS:       rd_next = 16'(flags_reg);
                ADDR_MICRO_LOAD0: rd_next = 16'(micro_load_q[0]);
                ADDR_MICRO_LOAD1: rd_next = 16'(micro_load_q[1]);
                default: begin
                    // channel windows, absent channels read zero
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (c < MAP_CHANNELS) begin
                            if (addr_reg == 4'(32'(ADDR_CH_LOAD) + c)) begin
                                wide = 32'(ch_load_q[c]);
                            end
                            if (addr_reg == 4'(32'(ADDR_CH_COUNT) + c)) begin
                                wide = 32'(ch_count_q[c]);
                            end
                        end
                    end
                    rd_next = wide[15:0];
                end
            endcase
        end
        fout_next = flags8[3:0];
        irq_next  = |(flags_next & irq_en_next);
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ge_reg        <= 1'b0;
            ch_en_reg     <= '0;
            sel_reg       <= '0;
            irq_en_reg    <= '0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            ge_reg        <= ge_next;
            ch_en_reg     <= ch_en_next;
            sel_reg       <= sel_next;
            irq_en_reg    <= irq_en_next;
            flags_reg     <= flags_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[3:0];
            data_reg <= s_tdata[19:4];
        end
        if (fire) begin
            rd_reg   <= rd_next;
            fout_reg <= fout_next;
            irq_reg  <= irq_next;
        end
    end

    // a held result agrees with the frozen state behind it
    a_irq_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (irq_reg == |(flags_reg & irq_en_reg)))
        else $error("irq in result disagrees with flags and enables");

    // state only moves when an operation passes through
    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(flags_reg) && $stable(ch_en_reg) && $stable(ge_reg)))
        else $error("timer state changed without an operation");

    // only reads return data
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (cmd_reg != CMD_READ)) |=> (m_tdata[15:0] == 16'h0000))
        else $error("nonzero read data on a non-read operation");

endmodule

// ===== bench/periodic_interrupt_timer_unit_test.sv =====
`timescale 1ns / 100ps

module periodic_interrupt_timer_unit_test
    import pit_pkg::*;
();

    localparam int NUM_CH = 4;
    localparam int CYCLE_LIMIT = 400000;
    // command code that the block must treat as a no-op
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one status transfer as the block reports it
    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  flag_bits;
        logic        irq;
    } timer_status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // reg_addr[3:0], write_data[19:4], zero[23:20]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // read_data[15:0], flag_bits[19:16], irq[20], zero[23:21]

    periodic_interrupt_timer_unit #(
        .NUM_CHANNELS (NUM_CH),
        .COUNT_BITS   (16)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // timer model: a private copy of every register and counter
    // ------------------------------------------------------------------
    logic                model_enable = 1'b0;
    logic [NUM_CH-1:0]   model_ch_enable = '0;
    logic [NUM_CH-1:0]   model_select = '0;
    logic [NUM_CH-1:0]   model_irq_enable = '0;
    logic [NUM_CH-1:0]   model_flags = '0;
    logic [7:0]          model_micro_load [NUM_MICRO] = '{default: '0};
    logic [7:0]          model_micro_count [NUM_MICRO] = '{default: '0};
    logic [15:0]         model_ch_load [NUM_CH] = '{default: '0};
    logic [15:0]         model_ch_count [NUM_CH] = '{default: '0};

    timer_status_t status_q[$];   // status transfers still owed by the block
    int            error_count = 0;
    int            items_sent = 0;
    int            idle_level = 2;   // 0 no gaps, 1 rare gaps, 2 a random gap, possibly none, before every transfer
    int            cycle_count = 0;

    function automatic void reload_channels(input logic [NUM_CH-1:0] mask);
        for (int c = 0; c < NUM_CH; c++)
            if (mask[c])
                model_ch_count[c] = model_ch_load[c];
    endfunction

    // one bus tick: micro-timers first, their pulses then clock the channels
    function automatic void model_tick();
        logic [NUM_MICRO-1:0] pulse;
        if (!model_enable)
            return;
        for (int m = 0; m < NUM_MICRO; m++) begin
            pulse[m] = (model_micro_count[m] == 8'd0);
            if (pulse[m])
                model_micro_count[m] = model_micro_load[m];
            else
                model_micro_count[m] = model_micro_count[m] - 8'd1;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            if (model_ch_enable[c] && pulse[model_select[c]]) begin
                if (model_ch_count[c] == 16'd0) begin
                    model_ch_count[c] = model_ch_load[c];
                    model_flags[c] = 1'b1;
                end else begin
                    model_ch_count[c] = model_ch_count[c] - 16'd1;
                end
            end
        end
    endfunction

    function automatic void model_write(input logic [3:0] addr, input logic [15:0] data);
        logic [NUM_CH-1:0] rise;
        case (addr)
            ADDR_ENABLE: begin
                // rising global enable restarts the micro-timers and live channels
                if (data[0] && !model_enable) begin
                    for (int m = 0; m < NUM_MICRO; m++)
                        model_micro_count[m] = model_micro_load[m];
                    reload_channels(model_ch_enable);
                end
                model_enable = data[0];
            end
            ADDR_FORCE_LOAD: begin
                reload_channels(data[NUM_CH-1:0]);
                for (int m = 0; m < NUM_MICRO; m++)
                    if (data[FORCE_MICRO_LSB + m])
                        model_micro_count[m] = model_micro_load[m];
            end
            ADDR_CH_ENABLE: begin
                rise = data[NUM_CH-1:0] & ~model_ch_enable;
                model_ch_enable = data[NUM_CH-1:0];
                reload_channels(rise);
            end
            ADDR_SELECT:      model_select = data[NUM_CH-1:0];
            ADDR_IRQ_ENABLE:  model_irq_enable = data[NUM_CH-1:0];
            ADDR_FLAGS:       model_flags = model_flags & ~data[NUM_CH-1:0];
            ADDR_MICRO_LOAD0: model_micro_load[0] = data[7:0];
            ADDR_MICRO_LOAD1: model_micro_load[1] = data[7:0];
            default: begin
                // counter window is read only
                if (addr >= ADDR_CH_LOAD && addr < ADDR_CH_LOAD + NUM_CH)
                    model_ch_load[2'(addr - ADDR_CH_LOAD)] = data;
            end
        endcase
    endfunction

    function automatic logic [15:0] model_read(input logic [3:0] addr);
        case (addr)
            ADDR_ENABLE:      return {15'd0, model_enable};
            ADDR_FORCE_LOAD:  return 16'd0;
            ADDR_CH_ENABLE:   return 16'(model_ch_enable);
            ADDR_SELECT:      return 16'(model_select);
            ADDR_IRQ_ENABLE:  return 16'(model_irq_enable);
            ADDR_FLAGS:       return 16'(model_flags);
            ADDR_MICRO_LOAD0: return 16'(model_micro_load[0]);
            ADDR_MICRO_LOAD1: return 16'(model_micro_load[1]);
            default: begin
                if (addr >= ADDR_CH_LOAD && addr < ADDR_CH_LOAD + NUM_CH)
                    return model_ch_load[2'(addr - ADDR_CH_LOAD)];
                if (addr >= ADDR_CH_COUNT && addr < ADDR_CH_COUNT + NUM_CH)
                    return model_ch_count[2'(addr - ADDR_CH_COUNT)];
                return 16'd0;
            end
        endcase
    endfunction

    // apply one operation to the model and give the status it should report
    function automatic timer_status_t advance_timer(input logic [1:0] cmd,
                                                    input logic [3:0] addr,
                                                    input logic [15:0] data);
        timer_status_t st;
        st.read_data = 16'd0;
        case (cmd)
            CMD_TICK:  model_tick();
            CMD_WRITE: model_write(addr, data);
            CMD_READ:  st.read_data = model_read(addr);
            default:   ;
        endcase
        st.flag_bits = 4'(model_flags);
        st.irq       = |(model_flags & model_irq_enable);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------
    function automatic int draw_wait();
        case (idle_level)
            0:       return 0;
            1:       return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    // one operation transfer; the model advances when the block takes it
    task automatic issue_op(input logic [1:0] cmd, input logic [3:0] addr,
                            input logic [15:0] data);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, data, addr};
        // values read right after the edge are the ones the block saw
        do @(posedge aclk); while (!s_tready);
        status_q.push_back(advance_timer(cmd, addr, data));
        items_sent++;
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [15:0] data);
        issue_op(CMD_WRITE, addr, data);
    endtask

    task automatic read_reg(input logic [3:0] addr);
        issue_op(CMD_READ, addr, 16'd0);
    endtask

    // micro loads stay short so channels expire often, now and then the extremes
    function automatic logic [15:0] pick_micro_load();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_channel_load();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    // registers at their extremes plus the corner cases of the map
    task automatic test_register_map();
        idle_level = 2;
        read_reg(ADDR_ENABLE);
        issue_op(CMD_TICK, ADDR_ENABLE, 16'hFFFF);          // disabled: tick is a no-op
        write_reg(ADDR_MICRO_LOAD0, 16'hFFFF);              // masked to 8 bits
        read_reg(ADDR_MICRO_LOAD0);
        write_reg(ADDR_MICRO_LOAD1, 16'h0001);
        write_reg(ADDR_CH_LOAD + 4'd0, 16'hFFFF);
        write_reg(ADDR_CH_LOAD + 4'd1, 16'h0000);
        write_reg(ADDR_CH_LOAD + 4'd2, 16'h0002);
        write_reg(ADDR_CH_LOAD + 4'd3, 16'h8000);
        read_reg(ADDR_CH_LOAD + 4'd0);
        write_reg(ADDR_CH_COUNT + 4'd0, 16'h1234);          // counter window ignores writes
        read_reg(ADDR_CH_COUNT + 4'd0);
        write_reg(ADDR_CH_ENABLE, 16'hFFFF);
        write_reg(ADDR_SELECT, 16'hFFFA);
        write_reg(ADDR_IRQ_ENABLE, 16'hFFFF);
        write_reg(ADDR_ENABLE, 16'hFFFF);                   // rising enable loads counters
        read_reg(ADDR_CH_COUNT + 4'd3);
        repeat (3) issue_op(CMD_TICK, 4'd0, 16'd0);
        read_reg(ADDR_FLAGS);
        write_reg(ADDR_FLAGS, 16'hFFFF);                    // write one to clear
        write_reg(ADDR_FORCE_LOAD, 16'h030F);
        read_reg(ADDR_FORCE_LOAD);
        issue_op(CMD_UNUSED, ADDR_ENABLE, 16'h0000);        // must not disable
        write_reg(ADDR_CH_ENABLE, 16'h0000);
        write_reg(ADDR_CH_ENABLE, 16'h0001);                // newly enabled channel reloads
        write_reg(ADDR_ENABLE, 16'h0000);
    endtask

    // well-formed setups followed by runs of ticks with software poking around
    task automatic test_periodic_programs(input int target);
        int n;
        while (items_sent < target) begin
            idle_level = $urandom_range(0, 2);
            write_reg(ADDR_MICRO_LOAD0, pick_micro_load());
            write_reg(ADDR_MICRO_LOAD1, pick_micro_load());
            for (int c = 0; c < NUM_CH; c++)
                if ($urandom_range(0, 2) != 0)
                    write_reg(ADDR_CH_LOAD + 4'(c), pick_channel_load());
            write_reg(ADDR_SELECT, 16'($urandom));
            write_reg(ADDR_IRQ_ENABLE, 16'($urandom));
            write_reg(ADDR_CH_ENABLE, 16'($urandom));
            write_reg(ADDR_ENABLE, 16'($urandom) | 16'd1);
            n = $urandom_range(30, 70);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0, 1:    read_reg(4'($urandom));
                    2:       read_reg(ADDR_FLAGS);
                    3:       write_reg(ADDR_FLAGS, 16'($urandom));
                    4:       write_reg(ADDR_FORCE_LOAD, 16'($urandom));
                    5:       write_reg(ADDR_CH_ENABLE, 16'($urandom));
                    6:       write_reg(4'($urandom), 16'($urandom));
                    default: issue_op(CMD_TICK, 4'($urandom), 16'($urandom));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
                write_reg(ADDR_ENABLE, 16'($urandom) & 16'hFFFE);
        end
    endtask

    // unstructured traffic, the unused command included
    task automatic test_random_traffic(input int count);
        repeat (count) begin
            if ($urandom_range(0, 31) == 0)
                idle_level = $urandom_range(0, 2);
            issue_op(2'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // result side: receiver stalls and the status check
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s expected 0x%0h got 0x%0h", what, want, got);
    endtask

    int            rx_wait = 0;
    timer_status_t want_status;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    note_mismatch("unexpected transfer", 0, m_tdata);
                end else begin
                    want_status = status_q.pop_front();
                    if (m_tdata[15:0] !== want_status.read_data)
                        note_mismatch("read_data", want_status.read_data, m_tdata[15:0]);
                    if (m_tdata[19:16] !== want_status.flag_bits)
                        note_mismatch("flag_bits", want_status.flag_bits, m_tdata[19:16]);
                    if (m_tdata[20] !== want_status.irq)
                        note_mismatch("irq", want_status.irq, m_tdata[20]);
                end
                rx_wait = draw_wait();
            end
            // a fresh stall may start right after each transfer
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("periodic_interrupt_timer_unit_test failed");
            $finish;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_TICK;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_map();
        test_periodic_programs(1450);
        test_random_traffic(300);

        s_tvalid <= 1'b0;
        // drain, then wait for anything stray to show up
        while (status_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (error_count == 0)
            $display("periodic_interrupt_timer_unit_test passed");
        else
            $display("periodic_interrupt_timer_unit_test failed");
        $finish;
    end

endmodule
